@@ sv/assert_macros.svh @@
// Assertion macros used by the chunked body decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising edge while out of reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/chbd_pkg.sv @@
// Package: types and constants of the chunked body decoder.
`timescale 1ns / 1ps

package chbd_pkg;

  // Width of the chunk size accumulator and the remaining byte counter
  localparam int SIZE_WIDTH = 32;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  // Result kinds
  typedef enum logic [1:0] {
    K_PAYLOAD = 2'd0,
    K_FINAL   = 2'd1,
    K_BADSIZE = 2'd2,
    K_EARLY   = 2'd3
  } kind_t;

  // Decoder phases, one-hot
  typedef enum logic [5:0] {
    PH_SIZE  = 6'b000001,
    PH_LF    = 6'b000010,
    PH_DATA  = 6'b000100,
    PH_TRAIL = 6'b001000,
    PH_DONE  = 6'b010000,
    PH_ERROR = 6'b100000
  } phase_t;

  // One result
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic       last;
  } res_t;

  // Results caused by one request: count 0..2, first in r0
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  // Queue status toward the top level
  typedef struct packed {
    logic [QCW-1:0] count;
    logic           room;
  } q_stat_t;

endpackage

@@ sv/chbd_if.sv @@
// Interfaces: body byte channel and result channel.
`timescale 1ns / 1ps

interface chbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       body_end;

  modport source (output valid, output data_byte, output body_end, input ready);
  modport sink (input valid, input data_byte, input body_end, output ready);
endinterface

interface chbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload;
  logic       last;

  modport source (output valid, output kind, output payload, output last, input ready);
  modport sink (input valid, input kind, input payload, input last, output ready);
endinterface

@@ sv/chbd_parser.sv @@
// Framing state machine: consumes one body byte per request, yields up to two results.
`timescale 1ns / 1ps

module chbd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 body_end,
  output chbd_pkg::res_pair_t  step
);

  localparam int W = chbd_pkg::SIZE_WIDTH;

  chbd_pkg::phase_t phase, phase_next;
  logic [W-1:0]     size_acc, size_acc_next;
  logic             digit_seen, digit_seen_next;
  logic             number_closed, number_closed_next;
  logic [W-1:0]     bytes_rem, bytes_rem_next;
  logic [1:0]       skip_count, skip_count_next;

  logic             hex_ok;
  logic [3:0]       hex_val;
  logic             blank;
  logic             e0;
  chbd_pkg::kind_t  e0_kind;
  logic [7:0]       e0_pay;
  logic             early;

  // Hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (data_byte >= "0" && data_byte <= "9") begin
      hex_val = 4'(data_byte - "0");
    end else if (data_byte >= "a" && data_byte <= "f") begin
      hex_val = 4'(data_byte - "a" + 8'd10);
    end else if (data_byte >= "A" && data_byte <= "F") begin
      hex_val = 4'(data_byte - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign blank = (data_byte == chbd_pkg::CH_SP) || (data_byte == chbd_pkg::CH_TAB) ||
                 (data_byte == chbd_pkg::CH_LF) || (data_byte == chbd_pkg::CH_VT) ||
                 (data_byte == chbd_pkg::CH_FF);

  // Next state and results for the byte on the input
  always_comb begin
    phase_next         = phase;
    size_acc_next      = size_acc;
    digit_seen_next    = digit_seen;
    number_closed_next = number_closed;
    bytes_rem_next     = bytes_rem;
    skip_count_next    = skip_count;
    e0                 = 1'b0;
    e0_kind            = chbd_pkg::K_PAYLOAD;
    e0_pay             = 8'd0;

    case (phase)
      chbd_pkg::PH_SIZE: begin
        if (data_byte == chbd_pkg::CH_CR) begin
          if (!digit_seen) begin
            e0         = 1'b1;
            e0_kind    = chbd_pkg::K_BADSIZE;
            phase_next = chbd_pkg::PH_ERROR;
          end else if (size_acc == '0) begin
            e0         = 1'b1;
            e0_kind    = chbd_pkg::K_FINAL;
            phase_next = chbd_pkg::PH_DONE;
          end else begin
            bytes_rem_next = size_acc;
            phase_next     = chbd_pkg::PH_LF;
          end
        end else if (!number_closed) begin
          if (hex_ok) begin
            // top nibble set: one more digit would overflow
            if (size_acc[W-1:W-4] != 4'd0) begin
              e0         = 1'b1;
              e0_kind    = chbd_pkg::K_BADSIZE;
              phase_next = chbd_pkg::PH_ERROR;
            end else begin
              size_acc_next   = {size_acc[W-5:0], hex_val};
              digit_seen_next = 1'b1;
            end
          end else if (!(blank && !digit_seen)) begin
            number_closed_next = 1'b1;
          end
        end
      end
      chbd_pkg::PH_LF: begin
        phase_next = chbd_pkg::PH_DATA;
      end
      chbd_pkg::PH_DATA: begin
        e0             = 1'b1;
        e0_kind        = chbd_pkg::K_PAYLOAD;
        e0_pay         = data_byte;
        bytes_rem_next = bytes_rem - 1'b1;
        if (bytes_rem == W'(1)) begin
          phase_next      = chbd_pkg::PH_TRAIL;
          skip_count_next = 2'd2;
        end
      end
      chbd_pkg::PH_TRAIL: begin
        skip_count_next = skip_count - 2'd1;
        if (skip_count_next == 2'd0) begin
          phase_next         = chbd_pkg::PH_SIZE;
          size_acc_next      = '0;
          digit_seen_next    = 1'b0;
          number_closed_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // End of body: flag an unfinished body, then back to the reset state
    early = body_end && (phase_next != chbd_pkg::PH_DONE) &&
            (phase_next != chbd_pkg::PH_ERROR);
    if (body_end) begin
      phase_next         = chbd_pkg::PH_SIZE;
      size_acc_next      = '0;
      digit_seen_next    = 1'b0;
      number_closed_next = 1'b0;
      bytes_rem_next     = '0;
      skip_count_next    = 2'd0;
    end
  end

  // Pack the results, last flag on the final one
  always_comb begin
    step.r0 = '{kind: chbd_pkg::K_EARLY, payload: 8'd0, last: 1'b1};
    step.r1 = '{kind: chbd_pkg::K_EARLY, payload: 8'd0, last: 1'b1};
    step.cnt = 2'd0;
    if (e0) begin
      step.r0  = '{kind: e0_kind, payload: e0_pay, last: !early};
      step.cnt = early ? 2'd2 : 2'd1;
    end else if (early) begin
      step.cnt = 2'd1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= chbd_pkg::PH_SIZE;
      size_acc      <= '0;
      digit_seen    <= 1'b0;
      number_closed <= 1'b0;
      bytes_rem     <= '0;
      skip_count    <= 2'd0;
    end else if (accept) begin
      phase         <= phase_next;
      size_acc      <= size_acc_next;
      digit_seen    <= digit_seen_next;
      number_closed <= number_closed_next;
      bytes_rem     <= bytes_rem_next;
      skip_count    <= skip_count_next;
    end
  end

endmodule

@@ sv/chbd_queue.sv @@
// Result queue: takes up to two results per cycle, delivers one per cycle while popped.
`timescale 1ns / 1ps

module chbd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  chbd_pkg::res_pair_t step,
  input  logic                pop,
  output chbd_pkg::res_t      head,
  output chbd_pkg::q_stat_t   stat
);

  chbd_pkg::res_t             mem [chbd_pkg::QDEPTH];
  logic [chbd_pkg::QAW-1:0]   wr_ptr, rd_ptr;
  logic [chbd_pkg::QCW-1:0]   count, count_next;
  logic [chbd_pkg::QCW-1:0]   n_in;
  logic                       do_pop;

  assign n_in   = push ? chbd_pkg::QCW'(step.cnt) : '0;
  assign do_pop = pop && (count != '0);

  assign head       = mem[rd_ptr];
  assign stat.count = count;
  // room for a full pair of results
  assign stat.room  = (count <= chbd_pkg::QCW'(chbd_pkg::QDEPTH - 2));

  assign count_next = count + n_in - chbd_pkg::QCW'(do_pop);

  // Storage writes
  always_ff @(posedge clk) begin
    if (push && step.cnt != 2'd0) begin
      mem[wr_ptr] <= step.r0;
    end
    if (push && step.cnt == 2'd2) begin
      mem[wr_ptr + 1'b1] <= step.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + chbd_pkg::QAW'(n_in);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

@@ sv/http_chunked_body_decoder.sv @@
// Top level: HTTP/1.1 chunked transfer body decoder.
//
//   channel  dir  payload                       role
//   body     in   data_byte[7:0], body_end      raw body bytes, one per request
//   result   out  kind[1:0], payload[7:0], last decoded bytes and status results
//
// One body byte is accepted per cycle; its results enter a four-entry queue
// in the same cycle and leave one per cycle while result.ready is high, so a
// byte giving one result streams at one per cycle. A byte may give two results;
// input stalls only when the queue lacks room for two. Reset (rst, synchronous)
// returns the framing state to the start of a size line and empties the queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module http_chunked_body_decoder (
  input  logic              clk,
  input  logic              rst,
  chbd_in_if.sink           body,
  chbd_out_if.source        result
);

  chbd_pkg::res_pair_t step;
  chbd_pkg::res_t      head;
  chbd_pkg::q_stat_t   stat;
  logic                accept;

  assign body.ready = stat.room;
  assign accept     = body.valid && body.ready;

  chbd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (body.data_byte),
    .body_end  (body.body_end),
    .step      (step)
  );

  chbd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .step (step),
    .pop  (result.ready),
    .head (head),
    .stat (stat)
  );

  // Result port from queue head
  assign result.valid   = (stat.count != '0);
  assign result.kind    = head.kind;
  assign result.payload = head.payload;
  assign result.last    = head.last;

  // Checks
  `ASSERT_CLK(a_cnt_bound, clk, rst, stat.count <= chbd_pkg::QDEPTH, "queue count past depth")
  `ASSERT_IMPLY(a_accept_room, clk, rst, accept, stat.count <= chbd_pkg::QDEPTH - 2, "request taken without room")
  `ASSERT_IMPLY(a_pair_last, clk, rst, step.cnt == 2'd2, !step.r0.last && step.r1.last && step.r1.kind == chbd_pkg::K_EARLY, "bad result pair")
  `ASSERT_IMPLY(a_status_zero, clk, rst, result.valid && result.kind != chbd_pkg::K_PAYLOAD, result.payload == 8'd0, "status result carries data")

endmodule

@@ tb/chbd_checker.sv @@
// Checker for the chunked body decoder: predicts results per accepted byte and compares.
`timescale 1ns / 1ps

module chbd_checker (
  input  logic clk,
  input  logic rst,
  chbd_in_if   body,
  chbd_out_if  result,
  output int   pending,
  output int   fails
);

  // Framing state of the predicted decoder
  chbd_pkg::phase_t                ph;
  logic [chbd_pkg::SIZE_WIDTH-1:0] size_acc;
  logic                            have_digit;
  logic                            size_closed;
  logic [chbd_pkg::SIZE_WIDTH-1:0] data_left;
  logic [1:0]                      trail_left;

  // Results still owed by the block, oldest first
  chbd_pkg::res_t owed_results[$];

  // Bit 4 set when the byte is a hex digit, low nibble holds its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'b0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == chbd_pkg::CH_SP || c == chbd_pkg::CH_TAB || c == chbd_pkg::CH_LF ||
           c == chbd_pkg::CH_VT || c == chbd_pkg::CH_FF;
  endfunction

  task automatic start_size_line();
    ph          = chbd_pkg::PH_SIZE;
    size_acc    = '0;
    have_digit  = 1'b0;
    size_closed = 1'b0;
  endtask

  task automatic restart_body();
    start_size_line();
    data_left  = '0;
    trail_left = 2'd0;
  endtask

  task automatic owe(input chbd_pkg::kind_t k, input logic [7:0] b);
    owed_results.push_back('{kind: k, payload: b, last: 1'b0});
  endtask

  // Advance the framing state by one body byte and queue what it yields
  task automatic decode_byte(input logic [7:0] c, input logic at_end);
    int         first_new;
    logic [4:0] nib;
    first_new = owed_results.size();
    nib       = hex_nibble(c);
    case (ph)
      chbd_pkg::PH_SIZE: begin
        if (c == chbd_pkg::CH_CR) begin
          if (!have_digit) begin
            owe(chbd_pkg::K_BADSIZE, 8'h00);
            ph = chbd_pkg::PH_ERROR;
          end else if (size_acc == '0) begin
            owe(chbd_pkg::K_FINAL, 8'h00);
            ph = chbd_pkg::PH_DONE;
          end else begin
            data_left = size_acc;
            ph        = chbd_pkg::PH_LF;
          end
        end else if (!size_closed) begin
          if (nib[4]) begin
            // a digit that no longer fits is a bad size at once
            if (size_acc[chbd_pkg::SIZE_WIDTH-1 -: 4] != 4'h0) begin
              owe(chbd_pkg::K_BADSIZE, 8'h00);
              ph = chbd_pkg::PH_ERROR;
            end else begin
              size_acc   = {size_acc[chbd_pkg::SIZE_WIDTH-5:0], nib[3:0]};
              have_digit = 1'b1;
            end
          end else if (!(is_blank(c) && !have_digit)) begin
            size_closed = 1'b1;
          end
        end
      end
      chbd_pkg::PH_LF: ph = chbd_pkg::PH_DATA;
      chbd_pkg::PH_DATA: begin
        owe(chbd_pkg::K_PAYLOAD, c);
        data_left = data_left - 1'b1;
        if (data_left == '0) begin
          ph         = chbd_pkg::PH_TRAIL;
          trail_left = 2'd2;
        end
      end
      chbd_pkg::PH_TRAIL: begin
        trail_left = trail_left - 1'b1;
        if (trail_left == 2'd0) start_size_line();
      end
      default: ;
    endcase

    // body over: report a cut-off body, then start afresh
    if (at_end) begin
      if (ph inside {chbd_pkg::PH_SIZE, chbd_pkg::PH_LF, chbd_pkg::PH_DATA,
                     chbd_pkg::PH_TRAIL}) owe(chbd_pkg::K_EARLY, 8'h00);
      restart_body();
    end
    if (owed_results.size() > first_new) owed_results[owed_results.size() - 1].last = 1'b1;
  endtask

  task automatic check_result(input logic [1:0] k, input logic [7:0] b, input logic l);
    chbd_pkg::res_t want;
    if (owed_results.size() == 0) begin
      $error("unexpected result: kind %0d payload %0h last %0d", k, b, l);
      fails++;
    end else begin
      want = owed_results.pop_front();
      if (k !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, k);
        fails++;
      end
      if (b !== want.payload) begin
        $error("payload: expected %0h, got %0h", want.payload, b);
        fails++;
      end
      if (l !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, l);
        fails++;
      end
    end
  endtask

  // Watch both channels at every rising edge
  always @(posedge clk) begin
    if (rst) begin
      restart_body();
      owed_results.delete();
      pending <= 0;
    end else begin
      if (body.valid && body.ready) decode_byte(body.data_byte, body.body_end);
      if (result.valid && result.ready) check_result(result.kind, result.payload, result.last);
      pending <= owed_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: clock, reset, chunked body stimulus, receiver back-pressure and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int N_ITEMS     = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  logic       clk = 1'b0;
  logic       rst;
  int         pending;
  int         fails;
  int         cycles;
  int         sent;
  int         tx_idle_pct;
  int         rx_idle_pct;
  logic       hold_req = 1'b0;
  logic [8:0] body_bytes[$];  // {body_end, data_byte}, next body to send

  chbd_in_if  body_ch ();
  chbd_out_if result_ch ();

  http_chunked_body_decoder i_dut (
    .clk(clk), .rst(rst), .body(body_ch), .result(result_ch)
  );

  chbd_checker i_checker (
    .clk(clk), .rst(rst), .body(body_ch), .result(result_ch),
    .pending(pending), .fails(fails)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- body construction ----

  task automatic push_byte(input logic [7:0] b);
    body_bytes.push_back({1'b0, b});
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic mark_end();
    body_bytes[body_bytes.size() - 1][8] = 1'b1;
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0: return chbd_pkg::CH_SP;
      1: return chbd_pkg::CH_TAB;
      2: return chbd_pkg::CH_LF;
      3: return chbd_pkg::CH_VT;
      default: return chbd_pkg::CH_FF;
    endcase
  endfunction

  // hex digit in random letter case
  function automatic logic [7:0] hex_char(input int unsigned d);
    if (d < 10) return 8'(8'h30 + d);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 10);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // neither hex, CR nor blank: closes a size field
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_hex(c) || c == chbd_pkg::CH_CR || c == chbd_pkg::CH_SP ||
           c == chbd_pkg::CH_TAB || c == chbd_pkg::CH_LF || c == chbd_pkg::CH_VT ||
           c == chbd_pkg::CH_FF);
    return c;
  endfunction

  function automatic logic [7:0] non_cr_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == chbd_pkg::CH_CR);
    return c;
  endfunction

  task automatic put_size(input int unsigned n, input int zeros);
    logic [7:0] digits[$];
    repeat (zeros) push_byte("0");
    do begin
      digits.push_front(hex_char(n % 16));
      n = n / 16;
    end while (n != 0);
    foreach (digits[i]) push_byte(digits[i]);
  endtask

  // size line: optional blanks, leading zeros and extension, then CR and (usually) LF
  task automatic chunk_header(input int unsigned n);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_byte(blank_char());
    put_size(n, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
    if ($urandom_range(0, 3) == 0) begin
      push_byte($urandom_range(0, 1) ? blank_char() : junk_char());
      repeat ($urandom_range(0, 3)) push_byte(non_cr_char());
    end
    push_byte(chbd_pkg::CH_CR);
    push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : chbd_pkg::CH_LF);
  endtask

  task automatic put_data(input int unsigned len);
    repeat (len) push_byte(8'($urandom_range(0, 255)));
  endtask

  // well-formed body: zero to three chunks, the zero chunk, trailer and maybe trailing junk
  task automatic build_chunked();
    int unsigned len;
    int          pick;
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(0, 49);
      if (pick == 0) len = $urandom_range(200, 300);
      else if (pick < 6) len = $urandom_range(13, 60);
      else len = $urandom_range(1, 12);
      chunk_header(len);
      put_data(len);
      if ($urandom_range(0, 9) == 0) put_data(2);
      else push_str("\r\n");
    end
    chunk_header(0);
    push_str("\r\n");
    if ($urandom_range(0, 3) == 0) put_data($urandom_range(1, 4));
  endtask

  // size line with no digits, junk first, or too many digits
  task automatic build_bad_line();
    case ($urandom_range(0, 2))
      0: begin
        repeat ($urandom_range(0, 2)) push_byte(blank_char());
        push_byte(chbd_pkg::CH_CR);
      end
      1: begin
        push_byte(junk_char());
        repeat ($urandom_range(0, 3)) push_byte(hex_char($urandom_range(0, 15)));
        push_byte(chbd_pkg::CH_CR);
      end
      default: begin
        push_byte(hex_char($urandom_range(1, 15)));
        repeat ($urandom_range(8, 9)) push_byte(hex_char($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) push_byte(chbd_pkg::CH_CR);
      end
    endcase
    put_data($urandom_range(0, 4));
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 10))
      body_bytes.push_back({1'($urandom_range(0, 5) == 0), 8'($urandom_range(0, 255))});
  endtask

  // ---- driving ----

  // offer one request after idling each cycle with the set odds, return at its acceptance
  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      body_ch.valid <= 1'b0;
      @(posedge clk);
    end
    body_ch.valid     <= 1'b1;
    body_ch.data_byte <= b;
    body_ch.body_end  <= e;
    @(posedge clk);
    while (!body_ch.ready) @(posedge clk);
  endtask

  task automatic send_body();
    logic [8:0] item;
    while (body_bytes.size() > 0) begin
      item = body_bytes.pop_front();
      send_byte(item[7:0], item[8]);
      sent++;
    end
  endtask

  // stop offering and wait until every owed result has come out
  task automatic drain();
    body_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic random_body();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 68) begin
      build_chunked();
    end else if (sel < 80) begin
      // cut a good body short
      build_chunked();
      repeat ($urandom_range(1, body_bytes.size() - 1)) void'(body_bytes.pop_back());
    end else if (sel < 90) begin
      build_bad_line();
    end else begin
      build_noise();
    end
    mark_end();
    send_body();
  endtask

  // ---- receiver: random ready, plus a long hold when asked ----
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---- run limit ----
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---- stimulus and verdict ----
  initial begin
    rst               <= 1'b1;
    body_ch.valid     <= 1'b0;
    body_ch.data_byte <= 8'h00;
    body_ch.body_end  <= 1'b0;
    sent        = 0;
    tx_idle_pct = 32;
    rx_idle_pct <= 73;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // blanks before the size, extension, payload extremes, zero chunk ending the body
    push_str("\t2 x\r\n");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_str("\r\n");
    push_str("0\r");
    mark_end();
    send_body();
    // junk before any digit
    push_str("g\r");
    mark_end();
    send_body();
    // size too wide for the counter
    push_str("fFfFfFfF0");
    mark_end();
    send_body();
    // line with no digits, then a dropped byte
    push_byte(chbd_pkg::CH_VT);
    push_byte(chbd_pkg::CH_FF);
    push_byte(chbd_pkg::CH_CR);
    push_byte(8'h00);
    mark_end();
    send_body();
    // body cut short on a payload byte: payload then early end
    push_str("2\r\n");
    push_byte(8'h80);
    mark_end();
    send_body();

    while (sent < N_ITEMS / 3) random_body();

    drain();
    tx_idle_pct = 73;
    rx_idle_pct <= 32;
    while (sent < 2 * N_ITEMS / 3) random_body();

    // receiver holds off while a long chunk keeps coming
    drain();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= ~hold_req;
    chunk_header(48);
    put_data(48);
    push_str("\r\n");
    chunk_header(0);
    mark_end();
    send_body();

    while (sent < N_ITEMS) random_body();

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/chbd_pkg.sv
sv/chbd_if.sv
sv/chbd_parser.sv
sv/chbd_queue.sv
sv/http_chunked_body_decoder.sv
tb/chbd_checker.sv
tb/tb.sv
